// ===== rtl/ctvo_pkg.sv =====
// ctvo_pkg: shared types and constants for the chiptune voice oscillator
// operation codes, voice codes, register indexes, duty edges and sample scale
// no dependencies
package ctvo_pkg;

    // operation codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_WAVE_WR = 2'd1;
    localparam logic [1:0] OP_PCM_WR  = 2'd2;

    // voice codes
    localparam logic [2:0] VOICE_PULSE_A = 3'd0;
    localparam logic [2:0] VOICE_PULSE_B = 3'd1;
    localparam logic [2:0] VOICE_TRI     = 3'd2;
    localparam logic [2:0] VOICE_NOISE   = 3'd3;
    localparam logic [2:0] VOICE_WAVE    = 3'd4;
    localparam logic [2:0] VOICE_PCM     = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_DUTY_A     = 3'd0;
    localparam logic [2:0] CFG_DUTY_B     = 3'd1;
    localparam logic [2:0] CFG_NOISE_SHRT = 3'd2;
    localparam logic [2:0] CFG_PCM_LEN    = 3'd3;
    localparam logic [2:0] CFG_PCM_LOOP   = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int INC_W      = 36;
    localparam int PHASE_W    = 32;
    localparam int POS_W      = 45;
    localparam int LFSR_W     = 15;
    localparam int LEN_W      = 13;
    localparam int SAMPLE_W   = 16;
    localparam int NUM_PHASE  = 5;

    localparam logic [LFSR_W-1:0]          LFSR_SEED  = 15'h4000;
    localparam logic signed [SAMPLE_W-1:0] FULL_POS   = 16'sd16384;
    localparam logic signed [SAMPLE_W-1:0] FULL_NEG   = -16'sd16384;
    localparam logic [PHASE_W-1:0]         PHASE_HALF = 32'h8000_0000;

    // duty edges: 1/8, 1/4, 1/2, 3/4 of a cycle
    localparam logic [PHASE_W-1:0] DUTY_EDGE [4] = '{
        32'h2000_0000, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000
    };

    // where the final sample comes from
    typedef enum logic [1:0] {
        SRC_CALC,
        SRC_WAVE,
        SRC_PCM
    } t_src;

    // unsigned byte with 128 as zero to signed Q14
    function automatic logic signed [SAMPLE_W-1:0] byte_to_q14(input logic [7:0] b);
        byte_to_q14 = {~b[7], ~b[7], b[6:0], 7'b000_0000};
    endfunction

endpackage

// ===== rtl/chiptune_voice_oscillator_unit.sv =====
// chiptune_voice_oscillator_unit: six-voice oscillator (pulse x2, triangle, noise,
// wavetable, pcm) with wavetable and pcm sample memories
// depends on ctvo_pkg
//
//  channel   signals                                        direction
//  request   i_valid / o_stall, i_op .. i_data              in
//  result    o_valid / i_stall, o_sample, o_pcm_ended       out
//  config    i_cfg_we, i_cfg_index, i_cfg_data              in, write only
//
// one request per cycle sustained while i_stall is low; a tick result passes through
// the input register, the memory read stage and the output register
// voice state is updated as a request leaves the input register
// synchronous active-low reset clears voice state and config, memories keep
// their contents and are undefined until written
// a stall on the result side holds each stage that has no empty stage after it
module chiptune_voice_oscillator_unit #(
    parameter int WAVE_DEPTH = 32,
    parameter int PCM_DEPTH  = 4096
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // request channel
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  logic [1:0]                                 i_op,
    input  logic [2:0]                                 i_voice,
    input  logic [ctvo_pkg::INC_W-1:0]                 i_increment,
    input  logic                                       i_restart,
    input  logic [11:0]                                i_address,
    input  logic [7:0]                                 i_data,
    // result channel
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output logic signed [ctvo_pkg::SAMPLE_W-1:0]       o_sample,
    output logic                                       o_pcm_ended,
    // configuration
    input  logic                                       i_cfg_we,
    input  logic [ctvo_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [ctvo_pkg::CFG_DATA_W-1:0]            i_cfg_data
);
    import ctvo_pkg::*;

    localparam int WAVE_AW = $clog2(WAVE_DEPTH);
    localparam int PCM_AW  = $clog2(PCM_DEPTH);
    localparam int PROD_W  = PHASE_W + WAVE_AW + 1;

    // configuration registers
    logic [1:0]       r_duty_a, r_duty_b;
    logic             r_noise_short;
    logic [LEN_W-1:0] r_pcm_len;
    logic             r_pcm_loop;

    // voice state
    logic [PHASE_W-1:0] r_phase [NUM_PHASE];
    logic [LFSR_W-1:0]  r_lfsr;
    logic [POS_W-1:0]   r_pcm_pos;

    // input register
    logic             r_in_valid;
    logic [1:0]       r_in_op;
    logic [2:0]       r_in_voice;
    logic [INC_W-1:0] r_in_increment;
    logic             r_in_restart;
    logic [11:0]      r_in_address;
    logic [7:0]       r_in_data;

    // middle stage
    logic                       r_mid_valid;
    t_src                       r_mid_src;
    logic signed [SAMPLE_W-1:0] r_mid_sample;
    logic                       r_mid_ended;
    logic [7:0]                 r_wave_rd, r_pcm_rd;

    // output register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_ended;

    // memories
    logic [7:0] r_wave_mem [WAVE_DEPTH];
    logic [7:0] r_pcm_mem  [PCM_DEPTH];

    // stage advance
    logic out_adv, mid_adv, in_adv;
    assign out_adv = !r_out_valid || !i_stall;
    assign mid_adv = !r_mid_valid || out_adv;
    assign in_adv  = !r_in_valid || mid_adv;
    assign o_stall = !in_adv;

    assign o_valid     = r_out_valid;
    assign o_sample    = r_out_sample;
    assign o_pcm_ended = r_out_ended;

    // voice datapath signals
    logic                       tick, leave;
    logic [PHASE_W-1:0]         ph_old, ph_start, n_phase;
    logic                       wrapped;
    logic [LFSR_W-1:0]          lfsr_start, lfsr_shift, n_lfsr;
    logic                       fb;
    logic [PHASE_W-1:0]         tri_dist;
    logic [PROD_W-1:0]          wave_prod;
    logic [WAVE_AW-1:0]         wave_ra, wave_wa;
    logic [LEN_W-1:0]           pcm_len_eff, pcm_idx;
    logic [POS_W-1:0]           pos_start, pos_play, n_pcm_pos;
    logic [PCM_AW-1:0]          pcm_ra, pcm_wa;
    logic [31:0]                addr_ext, pcm_idx_ext;
    logic                       wave_we, pcm_we;
    logic [1:0]                 duty_sel;
    t_src                       n_mid_src;
    logic signed [SAMPLE_W-1:0] n_mid_sample;
    logic                       n_mid_ended;
    logic                       n_mid_valid;
    logic                       phase_we, lfsr_we, pos_we;

    // voice update, sample and memory writes for the request in the input register
    always_comb begin
        tick  = r_in_valid && (r_in_op == OP_TICK) && (r_in_voice <= VOICE_PCM);
        leave = r_in_valid && mid_adv;

        // phase accumulator
        ph_old   = (r_in_voice < 3'(NUM_PHASE)) ? r_phase[r_in_voice] : '0;
        ph_start = r_in_restart ? '0 : ph_old;
        n_phase  = ph_start + r_in_increment[PHASE_W-1:0];
        wrapped  = {4'b0000, n_phase} < r_in_increment;

        // noise lfsr
        lfsr_start = (r_in_restart && r_in_voice == VOICE_NOISE) ? LFSR_SEED : r_lfsr;
        fb         = lfsr_start[0] ^ lfsr_start[1];
        lfsr_shift = {fb, lfsr_start[LFSR_W-1:1]};
        if (r_noise_short) begin
            lfsr_shift[6] = fb;
        end
        n_lfsr = wrapped ? lfsr_shift : lfsr_start;

        // triangle distance from mid cycle
        tri_dist = (n_phase >= PHASE_HALF) ? (n_phase - PHASE_HALF) : (PHASE_HALF - n_phase);

        // wavetable index
        wave_prod = PROD_W'(n_phase) * PROD_W'(WAVE_DEPTH);
        wave_ra   = wave_prod[PHASE_W +: WAVE_AW];

        // pcm position
        pcm_len_eff = (32'(r_pcm_len) > 32'(PCM_DEPTH)) ? LEN_W'(PCM_DEPTH) : r_pcm_len;
        pos_start   = (r_in_restart && r_in_voice == VOICE_PCM) ? '0 : r_pcm_pos;
        pcm_idx     = pos_start[POS_W-1:PHASE_W];
        pos_play    = pos_start;
        n_pcm_pos   = pos_start;
        n_mid_ended = 1'b0;
        n_mid_src   = SRC_CALC;
        n_mid_sample = '0;
        if (pcm_idx >= pcm_len_eff && r_pcm_loop) begin
            pos_play = '0;
            pcm_idx  = '0;
        end
        pcm_idx_ext = 32'(pcm_idx);
        pcm_ra      = pcm_idx_ext[PCM_AW-1:0];

        duty_sel = (r_in_voice == VOICE_PULSE_A) ? r_duty_a : r_duty_b;

        case (r_in_voice)
            VOICE_PULSE_A, VOICE_PULSE_B: begin
                n_mid_sample = (n_phase < DUTY_EDGE[duty_sel]) ? FULL_POS : FULL_NEG;
            end
            VOICE_TRI: begin
                n_mid_sample = FULL_POS - SAMPLE_W'(tri_dist[PHASE_W-1:16]);
            end
            VOICE_NOISE: begin
                n_mid_sample = n_lfsr[0] ? FULL_POS : FULL_NEG;
            end
            VOICE_WAVE: begin
                n_mid_src = SRC_WAVE;
            end
            VOICE_PCM: begin
                if (pcm_len_eff == '0 || pcm_idx >= pcm_len_eff) begin
                    n_mid_ended = 1'b1;
                end else begin
                    n_mid_src = SRC_PCM;
                    n_pcm_pos = pos_play + POS_W'(r_in_increment);
                end
            end
            default: begin
                n_mid_sample = '0;
            end
        endcase

        n_mid_valid = tick;
        phase_we    = leave && tick && (r_in_voice < 3'(NUM_PHASE));
        lfsr_we     = leave && tick && (r_in_voice == VOICE_NOISE);
        pos_we      = leave && tick && (r_in_voice == VOICE_PCM);

        // memory writes
        addr_ext = 32'(r_in_address);
        wave_wa  = addr_ext[WAVE_AW-1:0];
        pcm_wa   = addr_ext[PCM_AW-1:0];
        wave_we  = leave && (r_in_op == OP_WAVE_WR) && (addr_ext < 32'(WAVE_DEPTH));
        pcm_we   = leave && (r_in_op == OP_PCM_WR) && (addr_ext < 32'(PCM_DEPTH));
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_a      <= 2'd2;
            r_duty_b      <= 2'd2;
            r_noise_short <= 1'b0;
            r_pcm_len     <= '0;
            r_pcm_loop    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DUTY_A:     r_duty_a      <= i_cfg_data[1:0];
                CFG_DUTY_B:     r_duty_b      <= i_cfg_data[1:0];
                CFG_NOISE_SHRT: r_noise_short <= i_cfg_data[0];
                CFG_PCM_LEN:    r_pcm_len     <= i_cfg_data[LEN_W-1:0];
                CFG_PCM_LOOP:   r_pcm_loop    <= i_cfg_data[0];
                default:        r_pcm_loop    <= r_pcm_loop;
            endcase
        end
    end

    // voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PHASE; k++) begin
                r_phase[k] <= '0;
            end
            r_lfsr    <= LFSR_SEED;
            r_pcm_pos <= '0;
        end else begin
            if (phase_we) begin
                r_phase[r_in_voice] <= n_phase;
            end
            if (lfsr_we) begin
                r_lfsr <= n_lfsr;
            end
            if (pos_we) begin
                r_pcm_pos <= n_pcm_pos;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_valid;
        end
        if (in_adv && i_valid) begin
            r_in_op        <= i_op;
            r_in_voice     <= i_voice;
            r_in_increment <= i_increment;
            r_in_restart   <= i_restart;
            r_in_address   <= i_address;
            r_in_data      <= i_data;
        end
    end

    // middle stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (mid_adv) begin
            r_mid_valid <= leave && n_mid_valid;
        end
        if (mid_adv) begin
            r_mid_src    <= n_mid_src;
            r_mid_sample <= n_mid_sample;
            r_mid_ended  <= n_mid_ended;
        end
    end

    // wavetable memory, registered read
    always_ff @(posedge i_clk) begin
        if (wave_we) begin
            r_wave_mem[wave_wa] <= r_in_data;
        end
        if (mid_adv) begin
            r_wave_rd <= r_wave_mem[wave_ra];
        end
    end

    // pcm memory, registered read
    always_ff @(posedge i_clk) begin
        if (pcm_we) begin
            r_pcm_mem[pcm_wa] <= r_in_data;
        end
        if (mid_adv) begin
            r_pcm_rd <= r_pcm_mem[pcm_ra];
        end
    end

    // output register
    logic signed [SAMPLE_W-1:0] n_out_sample;
    always_comb begin
        case (r_mid_src)
            SRC_WAVE: n_out_sample = byte_to_q14(r_wave_rd);
            SRC_PCM:  n_out_sample = byte_to_q14(r_pcm_rd);
            default:  n_out_sample = r_mid_sample;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_mid_valid;
        end
        if (out_adv && r_mid_valid) begin
            r_out_sample <= n_out_sample;
            r_out_ended  <= r_mid_ended;
        end
    end

endmodule
